[hw/rtl/ple_pkg.sv]
package ple_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_LISTED = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_NONE   = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] operand;
    } t_in;

    typedef struct packed {
        logic signed [31:0] element_value;
        logic [2:0]         status;
        logic               is_last;
    } t_out;

endpackage

[hw/rtl/ple_ram.sv]
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/positional_list_engine.sv]
// positional_list_engine: ordered list of up to DEPTH signed 32-bit values.
// Command channel: a beat (i_cmd) is taken on a clock edge with start high
// and busy low. Results appear on o_result for one cycle with o_valid; the
// receiver cannot stall, so every result must be taken as it appears.
// Insert (front), delete of the front element, delete out of range: busy
// stays low, the one result shows in the cycle after acceptance, and the
// next beat can be taken on the following edge.
// Delete at position p >= 2: the cells in front of the removed one move
// down one place, each read through the single read port and then written;
// busy stays high while they move and the result shows as busy drops.
// Dump of n elements: busy stays high while the n cells are read, a result
// follows each read, and the final beat is flagged is_last;
// an empty list gives one empty beat the cycle after acceptance.
// The next beat can be taken on the edge that ends the last result.
// Throughput is set by the one memory read port.
// Reset clears the count (empty list); the cell memory is not cleared.
module positional_list_engine #(
    parameter int DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ple_pkg::t_in  i_cmd,
    output logic          o_valid,
    output ple_pkg::t_out o_result
);
    import ple_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_INS, S_DRD, S_DWR, S_DUMP} t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_valid;
    t_out          r_res;
    logic          r_last_rd;

    logic [AW-1:0] ram_raddr, ram_waddr;
    logic          ram_we;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          accept;
    logic [31:0]   pos;
    logic          pos_bad;
    logic [CW-1:0] del_idx;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pos = (i_cmd.operand[31] || i_cmd.operand == 32'sd0) ? 32'd1 : i_cmd.operand;
    assign pos_bad = (pos > 32'(r_count));
    assign del_idx = r_count - CW'(pos);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = i_cmd.operand;
        ram_raddr = r_idx[AW-1:0];
        if (accept && t_opcode'(i_cmd.opcode) == OP_INSERT && r_count < CW'(DEPTH)) begin
            ram_we = 1'b1;
        end else if (r_state == S_DWR) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx[AW-1:0] - AW'(1);
            ram_wdata = ram_rdata;
        end
        if (accept) begin
            ram_raddr = (t_opcode'(i_cmd.opcode) == OP_DUMP) ? AW'(r_count - CW'(1))
                                                             : AW'(del_idx + CW'(1));
        end else if (r_state == S_DUMP) begin
            // prefetch the cell behind the one being listed
            ram_raddr = r_idx[AW-1:0] - AW'(1);
        end
    end

    ple_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_valid   <= 1'b0;
            r_last_rd <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res.element_value <= '0;
                        r_res.is_last       <= 1'b1;
                        unique case (t_opcode'(i_cmd.opcode))
                            OP_INSERT: begin
                                r_valid <= 1'b1;
                                if (r_count < CW'(DEPTH)) begin
                                    r_count      <= r_count + CW'(1);
                                    r_res.status <= ST_DONE;
                                end else begin
                                    r_res.status <= ST_FULL;
                                end
                            end
                            OP_DELETE: begin
                                if (pos_bad || r_count == '0) begin
                                    r_valid      <= 1'b1;
                                    r_res.status <= ST_NONE;
                                end else if (del_idx + CW'(1) >= r_count) begin
                                    r_valid      <= 1'b1;
                                    r_res.status <= ST_DONE;
                                    r_count      <= r_count - CW'(1);
                                end else begin
                                    r_idx   <= del_idx + CW'(1);
                                    r_state <= S_DWR;
                                end
                            end
                            OP_DUMP: begin
                                if (r_count == '0) begin
                                    r_valid      <= 1'b1;
                                    r_res.status <= ST_EMPTY;
                                end else begin
                                    r_idx     <= r_count - CW'(1);
                                    r_last_rd <= (r_count == CW'(1));
                                    r_state   <= S_DUMP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DWR: begin
                    // data at r_idx is on ram_rdata and written to r_idx-1
                    if (r_idx + CW'(1) >= r_count) begin
                        r_count      <= r_count - CW'(1);
                        r_valid      <= 1'b1;
                        r_res.status <= ST_DONE;
                        r_res.is_last <= 1'b1;
                        r_res.element_value <= '0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_DRD;
                    end
                end
                S_DRD: begin
                    r_state <= S_DWR;
                end
                S_DUMP: begin
                    r_valid             <= 1'b1;
                    r_res.element_value <= ram_rdata;
                    r_res.status        <= ST_LISTED;
                    r_res.is_last       <= r_last_rd;
                    if (r_last_rd) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx     <= r_idx - CW'(1);
                        r_last_rd <= (r_idx == CW'(1));
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("count above depth");
    a_busy_no_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRD) |=> !o_valid) else $error("result during shift");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && r_last_rd) |=> (o_valid && o_result.is_last))
        else $error("dump end not flagged");
endmodule
